// ----- design/lbs_pkg.sv -----
`default_nettype none
package lbs_pkg;

   localparam int PALETTE_DEPTH_DEF = 64;
   localparam int MAX_INFLUENCES_DEF = 4;
   localparam int MATRIX_WORDS = 12;
   localparam int ONE_Q15 = 32768;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_SKIN = 1'b1;

   localparam logic REG_INFLUENCE_COUNT = 1'b0;
   localparam logic REG_OUTPUT_SCALE = 1'b1;

   localparam logic [2:0] INFLUENCE_COUNT_RESET = 3'd4;
   localparam logic signed [31:0] OUTPUT_SCALE_RESET = 32'sd65536;

   typedef struct packed {
      logic               mode;
      logic [7:0]         entry_index;
      logic [3:0]         element_select;
      logic signed [31:0] element_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [15:0]        weight_a;
      logic [15:0]        weight_b;
      logic [15:0]        weight_c;
      logic [31:0]        bone_indices;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- design/linear_blend_skinning.sv -----
`default_nettype none
// Channel  Ports                          Carries
// req      req_valid/req_ready/req_data   palette writes and vertices
// rsp      rsp_valid/rsp_ready/rsp_data   one skinned position per vertex
// csr      csr_we/csr_index/csr_wdata     influence_count, output_scale
//
// A palette write is done on its handshake; a vertex reads one matrix from the
// palette per influence (the clamped influence count), one per cycle while rsp is not stalled.
// After the last read, the result passes the s1 to s6 and rsp registers before it leaves.
// Reset is synchronous and clears control state and the registers; the
// palette is not cleared. A stalled rsp freezes every stage at once.
module linear_blend_skinning #(
   parameter int PALETTE_DEPTH = lbs_pkg::PALETTE_DEPTH_DEF,
   parameter int MAX_INFLUENCES = lbs_pkg::MAX_INFLUENCES_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  lbs_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output lbs_pkg::rsp_type       rsp_data,
   input  wire                    csr_we,
   input  wire                    csr_index,
   input  wire [31:0]             csr_wdata
);

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int ROW_W = lbs_pkg::MATRIX_WORDS * 32;

   logic [2:0]         count_ff;
   logic signed [31:0] scale_ff;

   logic [ROW_W-1:0] palette [PALETTE_DEPTH];

   logic               advance;
   logic               accept;
   logic               issue_now;
   logic               is_last;
   logic               busy_ff;
   logic [1:0]         k_ff;
   logic [1:0]         nlast_ff;
   logic signed [31:0] pos_ff [3];
   logic [15:0]        wts_ff [3];
   logic signed [18:0] wlast_ff;
   logic [31:0]        bones_ff;

   logic [2:0]         n_clamp;
   logic [1:0]         nlast_in;
   logic [17:0]        wsum_in;
   logic [7:0]         bone_sel;
   logic signed [18:0] w_issue;

   logic               s1_valid_ff, s1_first_ff, s1_last_ff, s1_ok_ff;
   logic [ROW_W-1:0]   rd_ff;
   logic signed [31:0] s1_pos_ff [3];
   logic signed [18:0] s1_w_ff;

   logic               s2_valid_ff, s2_first_ff, s2_last_ff;
   logic signed [63:0] s2_p_ff [3][3];
   logic signed [31:0] s2_t_ff [3];
   logic signed [18:0] s2_w_ff;
   logic [ROW_W-1:0]   mat;

   logic               s3_valid_ff, s3_first_ff, s3_last_ff;
   logic signed [31:0] s3_xf_ff [3];
   logic signed [18:0] s3_w_ff;

   logic               s4_valid_ff, s4_first_ff, s4_last_ff;
   logic signed [50:0] s4_wp_ff [3];

   logic signed [52:0] acc_ff [3];
   logic signed [52:0] acc_in [3];
   logic               s5_valid_ff;
   logic signed [31:0] s5_blend_ff [3];

   logic               s6_valid_ff;
   logic signed [63:0] s6_sp_ff [3];

   logic               rsp_valid_ff;
   lbs_pkg::rsp_type   rsp_data_ff;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign is_last = (k_ff == nlast_ff);
   assign req_ready = advance && (!busy_ff || is_last);
   assign accept = req_valid && req_ready;
   assign issue_now = busy_ff && advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= lbs_pkg::INFLUENCE_COUNT_RESET;
         scale_ff <= lbs_pkg::OUTPUT_SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lbs_pkg::REG_INFLUENCE_COUNT: count_ff <= csr_wdata[2:0];
            lbs_pkg::REG_OUTPUT_SCALE: scale_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      n_clamp = count_ff;
      if (n_clamp == 3'd0) begin
         n_clamp = 3'd1;
      end
      if (n_clamp > 3'(MAX_INFLUENCES)) begin
         n_clamp = 3'(MAX_INFLUENCES);
      end
      nlast_in = 2'(n_clamp - 3'd1);
      wsum_in = ((nlast_in > 2'd0) ? 18'(req_data.weight_a) : 18'd0)
              + ((nlast_in > 2'd1) ? 18'(req_data.weight_b) : 18'd0)
              + ((nlast_in > 2'd2) ? 18'(req_data.weight_c) : 18'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept && req_data.mode == lbs_pkg::MODE_SKIN) begin
         busy_ff <= 1'b1;
      end else if (issue_now && is_last) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.mode == lbs_pkg::MODE_SKIN) begin
         k_ff <= 2'd0;
         nlast_ff <= nlast_in;
         pos_ff[0] <= req_data.pos_x;
         pos_ff[1] <= req_data.pos_y;
         pos_ff[2] <= req_data.pos_z;
         wts_ff[0] <= req_data.weight_a;
         wts_ff[1] <= req_data.weight_b;
         wts_ff[2] <= req_data.weight_c;
         wlast_ff <= 19'(lbs_pkg::ONE_Q15) - $signed({1'b0, wsum_in});
         bones_ff <= req_data.bone_indices;
      end else if (issue_now && !is_last) begin
         k_ff <= k_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.mode == lbs_pkg::MODE_WRITE
          && {1'b0, req_data.entry_index} < 9'(PALETTE_DEPTH)
          && req_data.element_select < 4'(lbs_pkg::MATRIX_WORDS)) begin
         palette[req_data.entry_index[AW-1:0]][req_data.element_select*32 +: 32]
            <= req_data.element_value;
      end
   end

   assign bone_sel = bones_ff[k_ff*8 +: 8];

   always_comb begin
      if (is_last) begin
         w_issue = wlast_ff;
      end else begin
         w_issue = $signed({3'b000, wts_ff[k_ff]});
      end
   end

   always_ff @(posedge clock) begin
      if (issue_now) begin
         rd_ff <= palette[bone_sel[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= issue_now;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff && s4_last_ff;
         s6_valid_ff <= s5_valid_ff;
         rsp_valid_ff <= s6_valid_ff;
      end
   end

   assign mat = s1_ok_ff ? rd_ff : '0;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc_in[c] = (s4_first_ff ? 53'sd0 : acc_ff[c]) + 53'(s4_wp_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_first_ff <= (k_ff == 2'd0);
         s1_last_ff <= is_last;
         s1_ok_ff <= ({1'b0, bone_sel} < 9'(PALETTE_DEPTH));
         s1_pos_ff <= pos_ff;
         s1_w_ff <= w_issue;

         s2_first_ff <= s1_first_ff;
         s2_last_ff <= s1_last_ff;
         s2_w_ff <= s1_w_ff;
         for (int c = 0; c < 3; c++) begin
            s2_t_ff[c] <= $signed(mat[(9 + c)*32 +: 32]);
            for (int r = 0; r < 3; r++) begin
               s2_p_ff[c][r] <= s1_pos_ff[r] * $signed(mat[(r*3 + c)*32 +: 32]);
            end
         end

         s3_first_ff <= s2_first_ff;
         s3_last_ff <= s2_last_ff;
         s3_w_ff <= s2_w_ff;
         for (int c = 0; c < 3; c++) begin
            s3_xf_ff[c] <= lbs_pkg::sat32((66'($signed({s2_t_ff[c], 16'h0000}))
                           + 66'(s2_p_ff[c][0]) + 66'(s2_p_ff[c][1])
                           + 66'(s2_p_ff[c][2])) >>> 16);
         end

         s4_first_ff <= s3_first_ff;
         s4_last_ff <= s3_last_ff;
         for (int c = 0; c < 3; c++) begin
            s4_wp_ff[c] <= 51'(s3_xf_ff[c]) * 51'(s3_w_ff);
         end

         if (s4_valid_ff) begin
            for (int c = 0; c < 3; c++) begin
               acc_ff[c] <= acc_in[c];
               s5_blend_ff[c] <= lbs_pkg::sat32(66'(acc_in[c] >>> 15));
            end
         end

         for (int c = 0; c < 3; c++) begin
            s6_sp_ff[c] <= s5_blend_ff[c] * scale_ff;
         end

         rsp_data_ff.out_x <= lbs_pkg::sat32(66'(s6_sp_ff[0] >>> 16));
         rsp_data_ff.out_y <= lbs_pkg::sat32(66'(s6_sp_ff[1] >>> 16));
         rsp_data_ff.out_z <= lbs_pkg::sat32(66'(s6_sp_ff[2] >>> 16));
      end
   end

   a_hold_while_issuing: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !is_last) |-> !req_ready)
      else $error("new item taken while a vertex is still issuing");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (k_ff <= nlast_ff))
      else $error("influence counter ran past the last influence");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s6_valid_ff))
      else $error("result appeared without a finished vertex behind it");

endmodule
`default_nettype wire
